// File: sv/world_to_screen_projection_unit_defines.svh
// ----------------------------------------------------------------------------
// World-to-screen projection assertion macros
// Shared assertion forms for the projection unit.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define W2S_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, checked during reset as well.
`define W2S_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/w2s_pkg.sv
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Widths, register indexes, reset values and pipeline types.
// ----------------------------------------------------------------------------
package w2s_pkg;

    localparam int WORLD_W  = 20;
    localparam int ROT_W    = 16;
    localparam int ROW_W    = 48;
    localparam int TR_W     = 21;
    localparam int TRANS_W  = 63;
    localparam int FOCAL_W  = 24;
    localparam int CENTER_W = 15;
    localparam int SCREEN_W = 16;
    localparam int PROD_W   = ROT_W + WORLD_W;     // one rotation product
    localparam int EYE_W    = 39;                  // eye coordinate, Q.14
    localparam int DIV_W    = 64;                  // dividend, divisor, remainder
    localparam int Q_W      = 18;                  // quotient bits kept before clamp
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 63;

    localparam logic [CFG_AW-1:0] REG_ROT_X   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ROT_Y   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ROT_Z   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TRANS   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_FOCAL_X = 3'd4;
    localparam logic [CFG_AW-1:0] REG_FOCAL_Y = 3'd5;
    localparam logic [CFG_AW-1:0] REG_CENTER_X = 3'd6;
    localparam logic [CFG_AW-1:0] REG_CENTER_Y = 3'd7;

    localparam logic [ROW_W-1:0]   ROT_X_RST = 48'h4000_0000_0000;
    localparam logic [ROW_W-1:0]   ROT_Y_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]   ROT_Z_RST = 48'h0000_0000_4000;
    localparam logic [FOCAL_W-1:0] FOCAL_RST = 24'h01_0000;

    typedef struct packed {
        logic              vis;
        logic              negx;
        logic              negy;
        logic              ovfx;
        logic              ovfy;
        logic [DIV_W-1:0]  den;
        logic [DIV_W-1:0]  remx;
        logic [DIV_W-1:0]  remy;
        logic [Q_W-1:0]    qx;
        logic [Q_W-1:0]    qy;
    } div_stage_t;

    function automatic logic signed [SCREEN_W-1:0] sat16(input logic signed [Q_W+2:0] v);
        logic signed [Q_W+2:0] hi;
        logic signed [Q_W+2:0] lo;
        hi = (Q_W+3)'(32767);
        lo = -(Q_W+3)'(32768);
        if (v > hi)
            return SCREEN_W'(hi);
        else if (v < lo)
            return SCREEN_W'(lo);
        return v[SCREEN_W-1:0];
    endfunction

endpackage

// File: sv/world_to_screen_projection_unit.sv
// ----------------------------------------------------------------------------
// World-to-screen projection unit
// Rotates and translates a world point into eye space, then projects it.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one world point per item (tdata: world_x, world_y, world_z).
//   m_axis returns one result per item: tdata holds screen_x, screen_y, and
//   tuser holds the visible flag. Hidden points return zero coordinates.
//   cfg_we/cfg_addr/cfg_wdata write the camera registers; write only while
//   the pipeline is empty.
// Timing:
//   Fully pipelined, one item per cycle while the output is not stalled,
//   through 23 register stages: rotation products, eye sum, focal product,
//   divider setup, 18 restoring divider steps (one quotient bit each) and
//   the output register.
// Reset:
//   rst_n clears all valid bits and loads the identity-like camera defaults.
// Stall:
//   When the output holds an untaken item, the whole pipeline freezes and
//   s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_unit_defines.svh"

module world_to_screen_projection_unit
    import w2s_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,   // world_x[19:0], world_y[39:20], world_z[59:40]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // screen_x[15:0], screen_y[31:16]
    output logic                m_axis_tuser,   // visible
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata
);

    // configuration
    logic [ROW_W-1:0]    rot_reg [3];
    logic [TRANS_W-1:0]  trans_reg;
    logic [FOCAL_W-1:0]  focal_x_reg;
    logic [FOCAL_W-1:0]  focal_y_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0]   <= ROT_X_RST;
            rot_reg[1]   <= ROT_Y_RST;
            rot_reg[2]   <= ROT_Z_RST;
            trans_reg    <= '0;
            focal_x_reg  <= FOCAL_RST;
            focal_y_reg  <= FOCAL_RST;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ROT_X:    rot_reg[0]   <= cfg_wdata[ROW_W-1:0];
                REG_ROT_Y:    rot_reg[1]   <= cfg_wdata[ROW_W-1:0];
                REG_ROT_Z:    rot_reg[2]   <= cfg_wdata[ROW_W-1:0];
                REG_TRANS:    trans_reg    <= cfg_wdata[TRANS_W-1:0];
                REG_FOCAL_X:  focal_x_reg  <= cfg_wdata[FOCAL_W-1:0];
                REG_FOCAL_Y:  focal_y_reg  <= cfg_wdata[FOCAL_W-1:0];
                REG_CENTER_X: center_x_reg <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_wdata[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: global advance when output is free or being taken
    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    logic v1_reg, v2_reg, v3_reg;
    logic [Q_W:0] dv_valid_reg;

    // stage 1: nine products
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                prod_next[i][j] = $signed(rot_reg[i][ROT_W*j +: ROT_W])
                                * $signed(s_axis_tdata[WORLD_W*j +: WORLD_W]);
    end

    // stage 2: eye coordinates
    logic signed [EYE_W-1:0] eye_reg [3];
    logic signed [EYE_W-1:0] eye_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            eye_next[i] = EYE_W'(prod_reg[i][0]) + EYE_W'(prod_reg[i][1])
                        + EYE_W'(prod_reg[i][2])
                        + (EYE_W'($signed(trans_reg[TR_W*i +: TR_W])) <<< 14);
    end

    // stage 3: visibility, depth, focal products
    logic                    vis3_reg;
    logic signed [EYE_W-1:0] depth_reg;
    logic signed [DIV_W-1:0] numx_reg;
    logic signed [DIV_W-1:0] numy_reg;
    logic signed [DIV_W-1:0] numx_next;
    logic signed [DIV_W-1:0] numy_next;

    assign numx_next = DIV_W'(eye_reg[0] * $signed({1'b0, focal_x_reg}));
    assign numy_next = DIV_W'(eye_reg[1] * $signed({1'b0, focal_y_reg}));

    // stage 4: divider setup (rounding bias, overflow detection)
    div_stage_t              dv_reg [Q_W+1];
    div_stage_t              dv_next [Q_W+1];
    logic [DIV_W-1:0]        magx;
    logic [DIV_W-1:0]        magy;
    logic [DIV_W-1:0]        den4;
    logic [DIV_W-1:0]        nx4;
    logic [DIV_W-1:0]        ny4;
    logic [DIV_W:0]          lim4;

    always_comb
    begin
        magx = numx_reg[DIV_W-1] ? DIV_W'(-numx_reg) : DIV_W'(numx_reg);
        magy = numy_reg[DIV_W-1] ? DIV_W'(-numy_reg) : DIV_W'(numy_reg);
        den4 = DIV_W'({depth_reg, 8'b0});
        nx4  = magx + (den4 >> 1);
        ny4  = magy + (den4 >> 1);
        lim4 = {1'b0, den4} << Q_W;
        dv_next[0].vis  = vis3_reg;
        dv_next[0].negx = numx_reg[DIV_W-1];
        dv_next[0].negy = numy_reg[DIV_W-1];
        dv_next[0].ovfx = {1'b0, nx4} >= lim4;
        dv_next[0].ovfy = {1'b0, ny4} >= lim4;
        dv_next[0].den  = den4;
        dv_next[0].remx = nx4;
        dv_next[0].remy = ny4;
        dv_next[0].qx   = '0;
        dv_next[0].qy   = '0;

        // restoring divider, one quotient bit per stage, MSB first
        for (int i = 0; i < Q_W; i++)
        begin
            logic [DIV_W-1:0] dsh;
            dsh = dv_reg[i].den << (Q_W - 1 - i);
            dv_next[i+1] = dv_reg[i];
            if (dv_reg[i].remx >= dsh)
            begin
                dv_next[i+1].remx = dv_reg[i].remx - dsh;
                dv_next[i+1].qx[Q_W-1-i] = 1'b1;
            end
            if (dv_reg[i].remy >= dsh)
            begin
                dv_next[i+1].remy = dv_reg[i].remy - dsh;
                dv_next[i+1].qy[Q_W-1-i] = 1'b1;
            end
        end
    end

    // output: sign, clamp, center offset, saturate
    div_stage_t               dl;
    logic [Q_W:0]             qmx;
    logic [Q_W:0]             qmy;
    logic signed [Q_W+2:0]    sqx;
    logic signed [Q_W+2:0]    sqy;
    logic signed [Q_W+2:0]    sumx;
    logic signed [Q_W+2:0]    sumy;
    logic                     vis_next;
    logic signed [SCREEN_W-1:0] sx_next;
    logic signed [SCREEN_W-1:0] sy_next;
    logic                     out_vis_reg;
    logic signed [SCREEN_W-1:0] out_sx_reg;
    logic signed [SCREEN_W-1:0] out_sy_reg;

    always_comb
    begin
        dl   = dv_reg[Q_W];
        qmx  = dl.ovfx ? (Q_W+1)'(1) << Q_W : {1'b0, dl.qx};
        qmy  = dl.ovfy ? (Q_W+1)'(1) << Q_W : {1'b0, dl.qy};
        sqx  = dl.negx ? -$signed({2'b0, qmx}) : $signed({2'b0, qmx});
        sqy  = dl.negy ? -$signed({2'b0, qmy}) : $signed({2'b0, qmy});
        sumx = $signed((Q_W+3)'(center_x_reg)) + sqx;
        sumy = $signed((Q_W+3)'(center_y_reg)) - sqy;
        vis_next = dl.vis;
        sx_next  = dl.vis ? sat16(sumx) : '0;
        sy_next  = dl.vis ? sat16(sumy) : '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            dv_valid_reg  <= {dv_valid_reg[Q_W-1:0], v3_reg};
            out_valid_reg <= dv_valid_reg[Q_W];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            eye_reg   <= eye_next;
            vis3_reg  <= eye_reg[2][EYE_W-1];
            depth_reg <= -eye_reg[2];
            numx_reg  <= numx_next;
            numy_reg  <= numy_next;
            dv_reg    <= dv_next;
            out_vis_reg <= vis_next;
            out_sx_reg  <= sx_next;
            out_sy_reg  <= sy_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_vis_reg;
    assign m_axis_tdata  = {out_sy_reg, out_sx_reg};

    `W2S_ASSERT(a_hidden_zero,
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0,
        "hidden point with nonzero coordinates")
    `W2S_ASSERT(a_div_rem,
        dv_valid_reg[Q_W] && dl.vis && !dl.ovfx |-> dl.remx < dl.den,
        "divider remainder not below divisor")
    `W2S_ASSERT(a_enter,
        s_axis_tvalid && s_axis_tready |=> v1_reg,
        "accepted item did not enter the pipeline")

endmodule

// File: tb/world_to_screen_projection_unit_tb.sv
// ----------------------------------------------------------------------------
// World-to-screen projection unit testbench
// Streams world points through the unit under several camera setups and checks
// every projected result against a fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module world_to_screen_projection_unit_tb
    import w2s_pkg::*;
();

    localparam int  LATENCY   = 23;
    localparam int  DRAIN     = LATENCY + 20;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                       vis;
        logic signed [SCREEN_W-1:0] sx;
        logic signed [SCREEN_W-1:0] sy;
    } proj_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [31:0]         m_axis_tdata;
    logic                m_axis_tuser;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;

    // camera copy used for prediction
    logic [ROW_W-1:0]    cam_rot [3];
    logic [TRANS_W-1:0]  cam_trans;
    logic [FOCAL_W-1:0]  cam_fx;
    logic [FOCAL_W-1:0]  cam_fy;
    logic [CENTER_W-1:0] cam_cx;
    logic [CENTER_W-1:0] cam_cy;

    logic [63:0] point_queue [$];
    proj_t       proj_expected [$];
    int          send_gap;
    int          recv_stall;
    bit          no_idle;
    int          errors;
    int          points_sent;
    int          results_seen;
    int          visible_seen;
    longint      cycles;

    world_to_screen_projection_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + (den >>> 1)) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [SCREEN_W-1:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[SCREEN_W-1:0];
    endfunction

    function automatic proj_t project_point(input logic [63:0] pt);
        longint world [3];
        longint eye [3];
        longint depth;
        proj_t  r;
        for (int j = 0; j < 3; j++)
            world[j] = longint'($signed(pt[WORLD_W*j +: WORLD_W]));
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(cam_trans[TR_W*i +: TR_W])) * 16384;
            for (int j = 0; j < 3; j++)
                eye[i] += longint'($signed(cam_rot[i][ROT_W*j +: ROT_W])) * world[j];
        end
        if (eye[2] >= 0)
        begin
            r = '0;
        end
        else
        begin
            depth = -eye[2] * 256;
            r.vis = 1'b1;
            r.sx  = clamp16(longint'(cam_cx) + round_div(eye[0] * longint'(cam_fx), depth));
            r.sy  = clamp16(longint'(cam_cy) - round_div(eye[1] * longint'(cam_fy), depth));
        end
        return r;
    endfunction

    function automatic logic [63:0] make_point(input int wx, input int wy, input int wz);
        return {4'b0, wz[19:0], wy[19:0], wx[19:0]};
    endfunction

    // sender: one gap draw per item, none while no_idle is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                proj_expected.push_back(project_point(s_axis_tdata));
                points_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (point_queue.size() > 0)
                begin
                    s_axis_tdata  <= point_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= no_idle ? 0 : $urandom_range(0, 8);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each result against the oldest prediction, then draw a stall
    always @(posedge clk or negedge rst_n)
    begin
        proj_t want;
        proj_t got;
        int    draw;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.vis = m_axis_tuser;
                got.sx  = m_axis_tdata[15:0];
                got.sy  = m_axis_tdata[31:16];
                results_seen++;
                if (got.vis)
                    visible_seen++;
                if (proj_expected.size() == 0)
                begin
                    $display("%0t: unexpected result vis=%0b x=%0d y=%0d",
                             $time, got.vis, got.sx, got.sy);
                    errors++;
                end
                else
                begin
                    want = proj_expected.pop_front();
                    if (got.vis !== want.vis)
                    begin
                        $display("%0t: visible expected %0b actual %0b", $time, want.vis, got.vis);
                        errors++;
                    end
                    if (got.sx !== want.sx)
                    begin
                        $display("%0t: screen_x expected %0d actual %0d", $time, want.sx, got.sx);
                        errors++;
                    end
                    if (got.sy !== want.sy)
                    begin
                        $display("%0t: screen_y expected %0d actual %0d", $time, want.sy, got.sy);
                        errors++;
                    end
                end
                draw          = no_idle ? 0 : $urandom_range(0, 8);
                recv_stall    <= draw;
                m_axis_tready <= (draw == 0);
            end
            else if (recv_stall > 0)
            begin
                recv_stall    <= recv_stall - 1;
                m_axis_tready <= (recv_stall == 1);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** world_to_screen_projection_unit: FAILED **");
            $finish;
        end
    end

    // writes all eight camera registers; bits above each register's width are dropped
    task automatic load_camera(input logic [CFG_DW-1:0] val [8]);
        for (int k = 0; k < 8; k++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_AW'(k);
            cfg_wdata <= val[k];
            case (CFG_AW'(k))
                REG_ROT_X:    cam_rot[0] = val[k][ROW_W-1:0];
                REG_ROT_Y:    cam_rot[1] = val[k][ROW_W-1:0];
                REG_ROT_Z:    cam_rot[2] = val[k][ROW_W-1:0];
                REG_TRANS:    cam_trans  = val[k][TRANS_W-1:0];
                REG_FOCAL_X:  cam_fx     = val[k][FOCAL_W-1:0];
                REG_FOCAL_Y:  cam_fy     = val[k][FOCAL_W-1:0];
                REG_CENTER_X: cam_cx     = val[k][CENTER_W-1:0];
                REG_CENTER_Y: cam_cy     = val[k][CENTER_W-1:0];
                default: ;
            endcase
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // waits until every queued point has been sent and its result checked
    task automatic drain;
        wait (point_queue.size() == 0 && !s_axis_tvalid && proj_expected.size() == 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic int rand_world(input bit narrow);
        if (narrow)
            return $urandom_range(0, 2000) - 1000;
        return int'($urandom_range(0, 20'hfffff)) - 524288;
    endfunction

    task automatic queue_random(input int n);
        bit narrow;
        for (int k = 0; k < n; k++)
        begin
            narrow = ($urandom_range(0, 1) == 0);
            point_queue.push_back(make_point(rand_world(narrow), rand_world(narrow),
                                             rand_world(narrow)));
        end
    endtask

    function automatic logic [CFG_DW-1:0] rand63;
        return CFG_DW'({$urandom(), $urandom()});
    endfunction

    initial
    begin
        logic [CFG_DW-1:0] cam [8];
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        errors       = 0;
        points_sent  = 0;
        results_seen = 0;
        visible_seen = 0;
        cycles       = 0;
        no_idle      = 1'b0;
        cam_rot[0]   = ROT_X_RST;
        cam_rot[1]   = ROT_Y_RST;
        cam_rot[2]   = ROT_Z_RST;
        cam_trans    = '0;
        cam_fx       = FOCAL_RST;
        cam_fy       = FOCAL_RST;
        cam_cx       = '0;
        cam_cy       = '0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset camera: eye = (wz, wy, wx), so wx < 0 is in front
        point_queue.push_back(make_point(-524288, 524287, -524288));
        point_queue.push_back(make_point(-524288, -524288, 524287));
        point_queue.push_back(make_point(-1, 0, 0));
        point_queue.push_back(make_point(0, 0, 0));            // on the eye plane
        point_queue.push_back(make_point(1, 5, 5));            // behind
        point_queue.push_back(make_point(524287, -524288, 524287));
        point_queue.push_back(make_point(-1, 524287, 524287)); // saturates
        point_queue.push_back(make_point(-1, -524288, -524288));
        point_queue.push_back(make_point(-1000, 3, -7));
        drain();

        // tiny focal gives half-pixel ties; nonzero center
        cam = '{63'h4000_0000_0000, 63'h0000_4000_0000, 63'h0000_0000_4000, 63'd0,
                63'd1, 63'd1, 63'd100, 63'd32767};
        load_camera(cam);
        point_queue.push_back(make_point(-1, 128, 128));
        point_queue.push_back(make_point(-1, -128, -128));
        point_queue.push_back(make_point(-1, 127, 129));
        point_queue.push_back(make_point(-2, 384, -384));
        drain();

        // zero focal: coordinates sit at the center
        cam = '{63'h4000_0000_0000, 63'h0000_4000_0000, 63'h0000_0000_4000, 63'd0,
                63'd0, 63'd0, 63'd32767, 63'd0};
        load_camera(cam);
        point_queue.push_back(make_point(-5, 1000, -1000));
        point_queue.push_back(make_point(-524288, 524287, 524287));
        point_queue.push_back(make_point(7, 1, 1));
        drain();

        // extremes: all-ones rows and translation, full focal
        cam = '{{63{1'b1}}, {63{1'b1}}, {63{1'b1}}, {63{1'b1}},
                {63{1'b1}}, {63{1'b1}}, 63'd0, 63'd0};
        load_camera(cam);
        point_queue.push_back(make_point(524287, 524287, 524287));
        point_queue.push_back(make_point(-524288, -524288, -524288));
        point_queue.push_back(make_point(1, 0, 0));
        queue_random(60);
        drain();

        // random camera setups with idling, except for one back-to-back phase
        for (int ph = 0; ph < 7; ph++)
        begin
            for (int k = 0; k < 8; k++)
                cam[k] = rand63();
            if (ph % 2 == 0)
            begin
                // top bit of tz set: eye z negative so most points are visible
                cam[REG_TRANS] = rand63() | {1'b1, 62'd0};
                cam[REG_FOCAL_X] = CFG_DW'($urandom_range(0, 20000));
                cam[REG_FOCAL_Y] = CFG_DW'($urandom_range(0, 20000));
            end
            no_idle = (ph == 3);
            load_camera(cam);
            queue_random(65);
            drain();
        end
        no_idle = 1'b0;

        $display("%0d points sent, %0d results checked (%0d visible), 11 camera setups",
                 points_sent, results_seen, visible_seen);
        $display("covered hidden points, half-pixel ties, zero focal and saturation");
        if (errors == 0)
            $display("** world_to_screen_projection_unit: PASSED **");
        else
            $display("** world_to_screen_projection_unit: FAILED **");
        $finish;
    end

endmodule
